// ===== rtl/core/kvt_pkg.sv =====
// Shared constants, types and codes for the key/value table core.
package kvt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int TYPE_W   = 2;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int ENT_W    = 7;
	localparam int ENTRY_W  = KEY_W + VAL_W;

	localparam int IN_TDATA_W  = ((KEY_W + VAL_W + 7) / 8) * 8;
	localparam int IN_TUSER_W  = TYPE_W;
	localparam int OUT_TDATA_W = ((VAL_W + ENT_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = STAT_W;
	localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - ENT_W;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TYPE_W-1:0] req_type_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [ENT_W-1:0]  ent_t;

	localparam req_type_t REQ_PUT    = 2'd0;
	localparam req_type_t REQ_GET    = 2'd1;
	localparam req_type_t REQ_REMOVE = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_MISS = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SEARCH  = 5'b00010,
		S_RESOLVE = 5'b00100,
		S_SHIFT   = 5'b01000,
		S_DONE    = 5'b10000
	} state_t;

	// Finished result handed from the sequencer to the output register
	typedef struct packed {
		status_t           status;
		logic [VAL_W-1:0]  read_value;
		ent_t              entries_held;
	} res_t;

endpackage

// ===== rtl/core/key_value_table_core.sv =====
// Top level of the key/value table core: stream ports, sequencer, table memory, output register.
// Keeps up to kvt_pkg::CAPACITY unique signed keys with values in insertion order and answers
// one put, get or remove per transaction, one result each. Keys are found by a linear search
// that reads one entry per cycle from the table memory through a single comparator, and a
// remove that hits shifts the later entries down one per cycle. s_axis_tready is low while a
// request is in work; a finished result waits in the output register without holding up the
// next request, and a further result stays in the sequencer, keeping s_axis_tready low, until
// that register drains. The table memory is not cleared: only entries below the count are
// ever used.
module key_value_table_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] req_key, [63:32] req_value
	input  logic [kvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] req_type
	input  logic [kvt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] read_value, [38:32] entries_held, [39] zero
	output logic [kvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// [1:0] status
	output logic [kvt_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	logic                              res_valid;
	logic                              res_ready;
	kvt_pkg::res_t                     res;
	kvt_pkg::res_t                     out_q;
	logic                              out_valid_q;

	logic                              mem_wr_en;
	kvt_pkg::idx_t                     mem_wr_addr;
	logic [kvt_pkg::ENTRY_W-1:0]       mem_wr_data;
	logic                              mem_rd_en;
	kvt_pkg::idx_t                     mem_rd_addr;
	logic [kvt_pkg::ENTRY_W-1:0]       mem_rd_data;

	kvt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_type    (s_axis_tuser[kvt_pkg::TYPE_W-1:0]),
		.req_key     (s_axis_tdata[kvt_pkg::KEY_W-1:0]),
		.req_value   (s_axis_tdata[kvt_pkg::KEY_W+kvt_pkg::VAL_W-1:kvt_pkg::KEY_W]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	kvt_ram #(
		.DATA_W (kvt_pkg::ENTRY_W),
		.ADDR_W (kvt_pkg::IDX_W),
		.DEPTH  (kvt_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{kvt_pkg::OUT_PAD_W{1'b0}}, out_q.entries_held, out_q.read_value};
	assign m_axis_tuser  = out_q.status;

endmodule

// ===== rtl/core/kvt_ram.sv =====
// Generic memory: one write port, one read port with registered read data.
module kvt_ram #(
	parameter int DATA_W = 64,
	parameter int ADDR_W = 6,
	parameter int DEPTH  = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/kvt_seq.sv =====
// Request sequencer: linear key search, table update and shift-down on removal.
module kvt_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	// request side
	input  logic                             req_valid,
	output logic                             req_ready,
	input  kvt_pkg::req_type_t               req_type,
	input  logic [kvt_pkg::KEY_W-1:0]        req_key,
	input  logic [kvt_pkg::VAL_W-1:0]        req_value,
	// result side
	output logic                             res_valid,
	input  logic                             res_ready,
	output kvt_pkg::res_t                    res,
	// table memory
	output logic                             mem_wr_en,
	output kvt_pkg::idx_t                    mem_wr_addr,
	output logic [kvt_pkg::ENTRY_W-1:0]      mem_wr_data,
	output logic                             mem_rd_en,
	output kvt_pkg::idx_t                    mem_rd_addr,
	input  logic [kvt_pkg::ENTRY_W-1:0]      mem_rd_data
);

	kvt_pkg::state_t              state_q, state_d;
	kvt_pkg::cnt_t                count_q, count_d;
	kvt_pkg::idx_t                idx_q, idx_d;
	logic                         found_q, found_d;
	kvt_pkg::req_type_t           type_q;
	logic [kvt_pkg::KEY_W-1:0]    key_q;
	logic [kvt_pkg::VAL_W-1:0]    val_q;
	kvt_pkg::status_t             status_q, status_d;
	logic [kvt_pkg::VAL_W-1:0]    rdval_q, rdval_d;

	logic [kvt_pkg::KEY_W-1:0]    rd_key;
	logic [kvt_pkg::VAL_W-1:0]    rd_val;
	logic                         key_hit;
	logic                         last_entry;
	logic                         more_shift;
	logic                         accept;

	assign rd_key     = mem_rd_data[kvt_pkg::ENTRY_W-1:kvt_pkg::VAL_W];
	assign rd_val     = mem_rd_data[kvt_pkg::VAL_W-1:0];
	// the one shared comparator
	assign key_hit    = (rd_key == key_q);
	assign last_entry = ((kvt_pkg::cnt_t'(idx_q) + kvt_pkg::cnt_t'(1)) == count_q);
	assign more_shift = ((kvt_pkg::cnt_t'(idx_q) + kvt_pkg::cnt_t'(2)) < count_q);

	assign req_ready  = (state_q == kvt_pkg::S_IDLE);
	assign accept     = req_valid && req_ready;
	assign res_valid  = (state_q == kvt_pkg::S_DONE);

	assign res.status       = status_q;
	assign res.read_value   = rdval_q;
	assign res.entries_held = kvt_pkg::ent_t'(count_q);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		found_d     = found_q;
		status_d    = status_q;
		rdval_d     = rdval_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_q;
		mem_wr_data = {key_q, val_q};
		mem_rd_en   = 1'b0;
		mem_rd_addr = idx_q;

		case (state_q)
			kvt_pkg::S_IDLE: begin
				if (accept) begin
					idx_d       = '0;
					found_d     = 1'b0;
					rdval_d     = '0;
					mem_rd_en   = 1'b1;
					mem_rd_addr = '0;
					state_d     = (count_q == '0) ? kvt_pkg::S_RESOLVE : kvt_pkg::S_SEARCH;
				end
			end
			kvt_pkg::S_SEARCH: begin
				if (key_hit) begin
					found_d = 1'b1;
					if (type_q == kvt_pkg::REQ_GET) begin
						rdval_d = rd_val;
					end
					state_d = kvt_pkg::S_RESOLVE;
				end else if (last_entry) begin
					state_d = kvt_pkg::S_RESOLVE;
				end else begin
					idx_d       = idx_q + kvt_pkg::idx_t'(1);
					mem_rd_en   = 1'b1;
					mem_rd_addr = idx_q + kvt_pkg::idx_t'(1);
				end
			end
			kvt_pkg::S_RESOLVE: begin
				state_d = kvt_pkg::S_DONE;
				case (type_q)
					kvt_pkg::REQ_PUT: begin
						if (found_q) begin
							mem_wr_en   = 1'b1;
							mem_wr_addr = idx_q;
							status_d    = kvt_pkg::ST_OK;
						end else if (count_q < kvt_pkg::cnt_t'(kvt_pkg::CAPACITY)) begin
							mem_wr_en   = 1'b1;
							mem_wr_addr = kvt_pkg::idx_t'(count_q);
							count_d     = count_q + kvt_pkg::cnt_t'(1);
							status_d    = kvt_pkg::ST_OK;
						end else begin
							status_d    = kvt_pkg::ST_FULL;
						end
					end
					kvt_pkg::REQ_GET: begin
						status_d = found_q ? kvt_pkg::ST_OK : kvt_pkg::ST_MISS;
					end
					kvt_pkg::REQ_REMOVE: begin
						if (found_q) begin
							status_d = kvt_pkg::ST_OK;
							if (last_entry) begin
								count_d = count_q - kvt_pkg::cnt_t'(1);
							end else begin
								// fetch the entry that moves into the gap
								mem_rd_en   = 1'b1;
								mem_rd_addr = idx_q + kvt_pkg::idx_t'(1);
								state_d     = kvt_pkg::S_SHIFT;
							end
						end else begin
							status_d = kvt_pkg::ST_MISS;
						end
					end
					default: begin
						status_d = kvt_pkg::ST_MISS;
					end
				endcase
			end
			kvt_pkg::S_SHIFT: begin
				// read one ahead while writing the entry fetched last cycle
				mem_wr_en   = 1'b1;
				mem_wr_addr = idx_q;
				mem_wr_data = mem_rd_data;
				if (more_shift) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = idx_q + kvt_pkg::idx_t'(2);
					idx_d       = idx_q + kvt_pkg::idx_t'(1);
				end else begin
					count_d = count_q - kvt_pkg::cnt_t'(1);
					state_d = kvt_pkg::S_DONE;
				end
			end
			kvt_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = kvt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kvt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvt_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		found_q  <= found_d;
		status_q <= status_d;
		rdval_q  <= rdval_d;
		if (accept) begin
			type_q <= req_type;
			key_q  <= req_key;
			val_q  <= req_value;
		end
	end

endmodule

// ===== rtl/core/kvt_checker.sv =====
// Port-level checks on the key/value table core, bound to the top level.
module kvt_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [kvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic [kvt_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	logic [kvt_pkg::VAL_W-1:0] out_value;
	kvt_pkg::ent_t             out_entries;

	assign out_value   = m_axis_tdata[kvt_pkg::VAL_W-1:0];
	assign out_entries = m_axis_tdata[kvt_pkg::VAL_W+kvt_pkg::ENT_W-1:kvt_pkg::VAL_W];

	// one request in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("new request taken while one is in work");

	a_full_means_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == kvt_pkg::ST_FULL))
			|-> (out_entries == kvt_pkg::ent_t'(kvt_pkg::CAPACITY)))
		else $error("full status with room left in the table");

	a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != kvt_pkg::ST_OK)) |-> (out_value == '0))
		else $error("non-zero value on a failed request");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result withdrawn before it was taken");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed while stalled");

endmodule

bind key_value_table_core kvt_checker u_kvt_checker (.*);

// ===== bench/key_value_table_core_test.sv =====
// Self-checking bench for key_value_table_core: directed and random put/get/remove traffic.
module key_value_table_core_test;

	localparam int     HALF_PERIOD  = 10;
	localparam int     RESET_CYCLES = 8;
	localparam int     CYCLE_LIMIT  = 1000000;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     DRAIN_CYCLES = 2 * (kvt_pkg::CAPACITY + 8);
	localparam int     KEY_POOL_N   = 96;
	localparam kvt_pkg::req_type_t REQ_NONE = 2'd3;

	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] MINUS_1 = 32'hFFFF_FFFF;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [kvt_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [kvt_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [kvt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [kvt_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

	// Shadow copy of the table
	logic [kvt_pkg::KEY_W-1:0] held_keys [kvt_pkg::CAPACITY];
	logic [kvt_pkg::VAL_W-1:0] held_vals [kvt_pkg::CAPACITY];
	int                        held_count = 0;

	kvt_pkg::res_t             pending_results [$];
	logic [kvt_pkg::KEY_W-1:0] key_pool [KEY_POOL_N];
	int                        fail_count  = 0;
	int                        cycle_count = 0;
	int                        burst_left  = 0;
	bit                        hold_off_request = 1'b0;

	key_value_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Position of a key in the shadow table, -1 when absent
	function automatic int find_held(input logic [kvt_pkg::KEY_W-1:0] key);
		int pos;
		pos = -1;
		for (int i = 0; i < held_count; i++)
			if (pos < 0 && held_keys[i] == key)
				pos = i;
		return pos;
	endfunction

	function automatic kvt_pkg::res_t apply_request(input kvt_pkg::req_type_t rtype,
			input logic [kvt_pkg::KEY_W-1:0] key, input logic [kvt_pkg::VAL_W-1:0] val);
		kvt_pkg::res_t r;
		int            pos;
		pos          = find_held(key);
		r.status     = kvt_pkg::ST_MISS;
		r.read_value = '0;
		case (rtype)
			kvt_pkg::REQ_PUT: begin
				if (pos >= 0) begin
					held_vals[pos] = val;
					r.status = kvt_pkg::ST_OK;
				end else if (held_count < kvt_pkg::CAPACITY) begin
					held_keys[held_count] = key;
					held_vals[held_count] = val;
					held_count++;
					r.status = kvt_pkg::ST_OK;
				end else begin
					r.status = kvt_pkg::ST_FULL;
				end
			end
			kvt_pkg::REQ_GET: begin
				if (pos >= 0) begin
					r.read_value = held_vals[pos];
					r.status     = kvt_pkg::ST_OK;
				end
			end
			kvt_pkg::REQ_REMOVE: begin
				if (pos >= 0) begin
					for (int i = pos; i + 1 < held_count; i++) begin
						held_keys[i] = held_keys[i+1];
						held_vals[i] = held_vals[i+1];
					end
					held_count--;
					r.status = kvt_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		r.entries_held = kvt_pkg::ent_t'(held_count);
		return r;
	endfunction

	// Offer one request; bursts of random length with random gaps in between
	task automatic send_request(input kvt_pkg::req_type_t rtype,
			input logic [kvt_pkg::KEY_W-1:0] key, input logic [kvt_pkg::VAL_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= rtype;
		s_axis_tdata  <= {val, key};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_request(rtype, key, val));
	endtask

	function automatic logic [kvt_pkg::KEY_W-1:0] pick_key(input bit prefer_held);
		if (prefer_held && held_count > 0 && $urandom_range(0, 9) < 7)
			return held_keys[$urandom_range(0, held_count - 1)];
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
	endfunction

	function automatic logic [kvt_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 39))
			0:       return INT_MIN;
			1:       return INT_MAX;
			2:       return MINUS_1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin : check_results
		kvt_pkg::res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with none expected: status %0d tdata %h", m_axis_tuser,
					m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[kvt_pkg::VAL_W-1:0] !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value,
						m_axis_tdata[kvt_pkg::VAL_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[kvt_pkg::VAL_W+kvt_pkg::ENT_W-1:kvt_pkg::VAL_W]
						!== want.entries_held) begin
					$error("entries_held: expected %0d, got %0d", want.entries_held,
						m_axis_tdata[kvt_pkg::VAL_W+kvt_pkg::ENT_W-1:kvt_pkg::VAL_W]);
					fail_count++;
				end
				if (m_axis_tdata[kvt_pkg::OUT_TDATA_W-1:kvt_pkg::VAL_W+kvt_pkg::ENT_W] !== '0)
						begin
					$error("pad: expected 0, got %b",
						m_axis_tdata[kvt_pkg::OUT_TDATA_W-1:kvt_pkg::VAL_W+kvt_pkg::ENT_W]);
					fail_count++;
				end
			end
		end
	end

	// Receiver: stretches of differing stall patterns, plus one long hold-off on request
	initial begin : result_ready
		int stretch;
		int mode;
		forever begin
			if (hold_off_request) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_request = 1'b0;
			end else begin
				stretch = $urandom_range(4, 60);
				mode    = $urandom_range(0, 3);
				for (int n = 0; n < stretch; n++) begin
					@(negedge clk);
					case (mode)
						0:       m_axis_tready <= 1'b1;
						1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
						2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
						default: m_axis_tready <= (n % 3 != 0);
					endcase
				end
			end
		end
	end

	task automatic init_key_pool();
		key_pool[0] = INT_MIN;
		key_pool[1] = INT_MAX;
		key_pool[2] = MINUS_1;
		key_pool[3] = 32'h0;
		key_pool[4] = 32'h1;
		for (int i = 5; i < KEY_POOL_N; i++)
			key_pool[i] = $urandom;
	endtask

	task automatic test_empty_table();
		send_request(kvt_pkg::REQ_GET, 32'h0, 32'h1234_5678);
		send_request(kvt_pkg::REQ_REMOVE, INT_MIN, 32'h0);
		send_request(REQ_NONE, INT_MAX, MINUS_1);
	endtask

	task automatic test_edge_keys();
		send_request(kvt_pkg::REQ_PUT, INT_MIN, INT_MAX);
		send_request(kvt_pkg::REQ_PUT, INT_MAX, INT_MIN);
		send_request(kvt_pkg::REQ_PUT, 32'h0, 32'h0);
		send_request(kvt_pkg::REQ_PUT, MINUS_1, MINUS_1);
		send_request(kvt_pkg::REQ_GET, INT_MIN, 32'h0);
		send_request(kvt_pkg::REQ_GET, INT_MAX, 32'h0);
		send_request(kvt_pkg::REQ_GET, MINUS_1, 32'h0);
		// replace keeps the position and the count
		send_request(kvt_pkg::REQ_PUT, INT_MIN, 32'hA5A5_5A5A);
		send_request(kvt_pkg::REQ_GET, INT_MIN, 32'h0);
		send_request(kvt_pkg::REQ_REMOVE, INT_MAX, 32'h0);
		send_request(kvt_pkg::REQ_GET, 32'h0, 32'h0);
		send_request(kvt_pkg::REQ_REMOVE, INT_MIN, 32'h0);
		send_request(kvt_pkg::REQ_REMOVE, MINUS_1, 32'h0);
		send_request(kvt_pkg::REQ_REMOVE, 32'h1, 32'h0);
		send_request(kvt_pkg::REQ_GET, INT_MAX, 32'h0);
		send_request(REQ_NONE, 32'h0, 32'h0);
		send_request(kvt_pkg::REQ_REMOVE, 32'h0, 32'h0);
	endtask

	task automatic test_fill_to_capacity();
		logic [kvt_pkg::KEY_W-1:0] k;
		while (held_count < kvt_pkg::CAPACITY)
			send_request(kvt_pkg::REQ_PUT, $urandom, pick_value());
		do k = $urandom; while (find_held(k) >= 0);
		send_request(kvt_pkg::REQ_PUT, k, pick_value());
		send_request(kvt_pkg::REQ_PUT, held_keys[kvt_pkg::CAPACITY-1], pick_value());
		send_request(kvt_pkg::REQ_GET, held_keys[kvt_pkg::CAPACITY-1], 32'h0);
		send_request(kvt_pkg::REQ_GET, k, 32'h0);
		// longest shift: remove the first entry of a full table
		send_request(kvt_pkg::REQ_REMOVE, held_keys[0], 32'h0);
		send_request(kvt_pkg::REQ_GET, held_keys[0], 32'h0);
		send_request(kvt_pkg::REQ_PUT, k, pick_value());
		send_request(kvt_pkg::REQ_REMOVE, held_keys[kvt_pkg::CAPACITY-1], 32'h0);
		while (held_count > 0) begin
			k = held_keys[$urandom_range(0, held_count - 1)];
			send_request(kvt_pkg::REQ_REMOVE, k, 32'h0);
			if ($urandom_range(0, 3) == 0)
				send_request(kvt_pkg::REQ_GET, k, 32'h0);
		end
	endtask

	task automatic test_back_pressure();
		hold_off_request = 1'b1;
		burst_left = 40;
		for (int i = 0; i < 24; i++)
			send_request(($urandom_range(0, 1) == 0) ? kvt_pkg::REQ_PUT : kvt_pkg::REQ_GET,
				pick_key(1'b1), pick_value());
		while (hold_off_request) @(posedge clk);
	endtask

	task automatic test_random_traffic(input int item_goal);
		int                 done_items;
		int                 phase_len;
		int                 phase_kind;
		int                 roll;
		kvt_pkg::req_type_t rtype;
		done_items = 0;
		while (done_items < item_goal) begin
			phase_len  = $urandom_range(40, 150);
			phase_kind = $urandom_range(0, 2);
			for (int n = 0; n < phase_len && done_items < item_goal; n++) begin
				roll = $urandom_range(0, 99);
				case (phase_kind)
					0: rtype = (roll < 65) ? kvt_pkg::REQ_PUT : (roll < 80) ? kvt_pkg::REQ_GET :
						(roll < 97) ? kvt_pkg::REQ_REMOVE : REQ_NONE;
					1: rtype = (roll < 20) ? kvt_pkg::REQ_PUT : (roll < 40) ? kvt_pkg::REQ_GET :
						(roll < 97) ? kvt_pkg::REQ_REMOVE : REQ_NONE;
					default: rtype = (roll < 40) ? kvt_pkg::REQ_PUT :
						(roll < 70) ? kvt_pkg::REQ_GET :
						(roll < 97) ? kvt_pkg::REQ_REMOVE : REQ_NONE;
				endcase
				send_request(rtype, pick_key(rtype != kvt_pkg::REQ_PUT || roll < 15),
					pick_value());
				if (rtype != REQ_NONE)
					done_items++;
			end
		end
	endtask

	initial begin
		init_key_pool();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_edge_keys();
		test_fill_to_capacity();
		test_back_pressure();
		test_random_traffic(800);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
